// ----- rtl/biped_center_of_pressure_filter_unit_assert.svh -----
// Assertion macros shared by the filter RTL.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef BIPED_CENTER_OF_PRESSURE_FILTER_UNIT_ASSERT_SVH
`define BIPED_CENTER_OF_PRESSURE_FILTER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BCOP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BCOP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/bcop_pkg.sv -----
package bcop_pkg;

  // Field and datapath widths
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned FRAC_W      = 16;
  localparam int unsigned MOM_W       = 64;
  localparam int unsigned SUM_W       = 40;
  localparam int unsigned DEN_W       = DATA_W + 1;
  localparam int unsigned IN_TDATA_W  = 8 * DATA_W;
  localparam int unsigned OUT_TDATA_W = 4 * DATA_W;

  // History ring geometry
  localparam int unsigned WINDOW_MAX  = 64;
  localparam int unsigned PTR_W       = $clog2(WINDOW_MAX);
  localparam int unsigned CNT_W       = $clog2(WINDOW_MAX + 1);
  localparam int unsigned ENTRY_W     = 2 * DATA_W;

  // Divider iteration counter: one quotient bit per step
  localparam int unsigned DIV_CNT_W   = $clog2(DATA_W);

  localparam logic [CNT_W-1:0] WL_RESET = CNT_W'(8);

  localparam logic signed [MOM_W-1:0]  MOM_MAX = {1'b0, {(MOM_W-1){1'b1}}};
  localparam logic signed [MOM_W-1:0]  MOM_MIN = {1'b1, {(MOM_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] Q_MAX   = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] Q_MIN   = {1'b1, {(DATA_W-1){1'b0}}};

  // Request to the shared divider
  typedef struct packed {
    logic                     start;
    logic signed [MOM_W-1:0]  num;
    logic signed [DEN_W-1:0]  den;
  } div_req_t;

  // Response from the shared divider
  typedef struct packed {
    logic                     done;
    logic signed [DATA_W-1:0] quot;
  } div_rsp_t;

endpackage

// ----- rtl/bcop_ram.sv -----
module bcop_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- rtl/bcop_div.sv -----
module bcop_div
  import bcop_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  typedef enum logic [3:0] {
    D_IDLE  = 4'b0001,
    D_CHECK = 4'b0010,
    D_ITER  = 4'b0100,
    D_DONE  = 4'b1000
  } div_state_e;

  div_state_e           state_q, state_d;
  logic                 neg_q, neg_d;
  logic                 ovf_q, ovf_d;
  logic [MOM_W-1:0]     magn_q, magn_d;
  logic [DEN_W-1:0]     magd_q, magd_d;
  logic [DATA_W-1:0]    rem_q, rem_d;
  logic [DATA_W-1:0]    lo_q, lo_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DEN_W-1:0]     trial;
  logic                 qbit;

  // Trial subtraction of one restoring-division step
  assign trial = {rem_q, lo_q[DATA_W-1]};
  assign qbit  = (trial >= magd_q);

  // Sequence one division: magnitudes, overflow check, one bit per cycle
  always_comb begin
    state_d = state_q;
    neg_d   = neg_q;
    ovf_d   = ovf_q;
    magn_d  = magn_q;
    magd_d  = magd_q;
    rem_d   = rem_q;
    lo_d    = lo_q;
    cnt_d   = cnt_q;
    case (state_q)
      D_IDLE: begin
        if (req_i.start) begin
          neg_d   = req_i.num[MOM_W-1] ^ req_i.den[DEN_W-1];
          magn_d  = req_i.num[MOM_W-1] ? MOM_W'(-req_i.num) : MOM_W'(req_i.num);
          magd_d  = req_i.den[DEN_W-1] ? DEN_W'(-req_i.den) : DEN_W'(req_i.den);
          state_d = D_CHECK;
        end
      end
      D_CHECK: begin
        // quotient of 2^32 or more cannot fit: flag it so the result saturates
        ovf_d   = ({1'b0, magn_q} >= {magd_q, {DATA_W{1'b0}}});
        rem_d   = magn_q[MOM_W-1:DATA_W];
        lo_d    = magn_q[DATA_W-1:0];
        cnt_d   = '0;
        state_d = D_ITER;
      end
      D_ITER: begin
        rem_d = qbit ? DATA_W'(trial - magd_q) : DATA_W'(trial);
        lo_d  = {lo_q[DATA_W-2:0], qbit};
        cnt_d = cnt_q + DIV_CNT_W'(1);
        if (cnt_q == '1) begin
          state_d = D_DONE;
        end
      end
      D_DONE: begin
        state_d = D_IDLE;
      end
      default: begin
        state_d = D_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q  <= neg_d;
    ovf_q  <= ovf_d;
    magn_q <= magn_d;
    magd_q <= magd_d;
    rem_q  <= rem_d;
    lo_q   <= lo_d;
    cnt_q  <= cnt_d;
  end

  // Apply sign and saturate to the 32-bit range
  always_comb begin
    rsp_o.done = (state_q == D_DONE);
    if (ovf_q) begin
      rsp_o.quot = neg_q ? Q_MIN : Q_MAX;
    end else if (neg_q) begin
      rsp_o.quot = lo_q[DATA_W-1] ? Q_MIN : DATA_W'(-lo_q);
    end else begin
      rsp_o.quot = lo_q[DATA_W-1] ? Q_MAX : lo_q;
    end
  end

endmodule

// ----- rtl/biped_center_of_pressure_filter_unit.sv -----
// Two-foot center-of-pressure estimator with a moving-average filter.
// Input stream (s_axis): one foot reading per transaction; tuser selects the
// foot (0 left, 1 right). A left transaction latches that foot's moments and
// vertical force and produces no output. A right transaction produces one
// output transaction (m_axis) with raw and averaged center of pressure.
// Config: cfg_we_i writes the window length (0 acts as 1, above 64 as 64)
// and empties the history; write only while the unit is idle.
// Timing: the unit takes one transaction at a time. A left item passes through
// four products on one 32x32 multiplier, then the latch. A right item runs the
// same multiplier steps, then four quotients on one radix-2 divider (raw x,
// raw y, avg x, avg y). Zero total force skips the raw quotients and leaves
// history untouched.
// Output: a result sits in an output register; the next input is accepted
// while it waits, and a finished result stalls only if the previous one is
// still untaken. Reset clears the latched foot terms, sums, fill count and
// write pointer, and sets the window length to 8.
`include "biped_center_of_pressure_filter_unit_assert.svh"

module biped_center_of_pressure_filter_unit
  import bcop_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // config: window_length
  input  logic                   cfg_we_i,
  input  logic [CNT_W-1:0]       cfg_wdata_i,
  // input stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // pos_x, pos_y, pos_z, torque_x, torque_y, force_x, force_y, force_z
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // func
  input  logic                   s_axis_tuser,
  // output stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // raw_x, raw_y, avg_x, avg_y
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // no_contact
  output logic                   m_axis_tuser
);

  typedef enum logic [17:0] {
    ST_IDLE = 18'h00001,
    ST_M1   = 18'h00002,
    ST_M2   = 18'h00004,
    ST_M3   = 18'h00008,
    ST_M4   = 18'h00010,
    ST_M5   = 18'h00020,
    ST_SUM  = 18'h00040,
    ST_CHK  = 18'h00080,
    ST_DXS  = 18'h00100,
    ST_DXW  = 18'h00200,
    ST_DYS  = 18'h00400,
    ST_DYW  = 18'h00800,
    ST_UPD  = 18'h01000,
    ST_AXS  = 18'h02000,
    ST_AXW  = 18'h04000,
    ST_AYS  = 18'h08000,
    ST_AYW  = 18'h10000,
    ST_OUT  = 18'h20000
  } state_e;

  function automatic logic signed [MOM_W-1:0] sat_add(input logic signed [MOM_W-1:0] a,
                                                      input logic signed [MOM_W-1:0] b);
    logic signed [MOM_W-1:0] s;
    s = a + b;
    if ((a[MOM_W-1] == b[MOM_W-1]) && (s[MOM_W-1] != a[MOM_W-1])) begin
      return a[MOM_W-1] ? MOM_MIN : MOM_MAX;
    end
    return s;
  endfunction

  function automatic logic signed [MOM_W-1:0] sat_sub(input logic signed [MOM_W-1:0] a,
                                                      input logic signed [MOM_W-1:0] b);
    logic signed [MOM_W-1:0] s;
    s = a - b;
    if ((a[MOM_W-1] != b[MOM_W-1]) && (s[MOM_W-1] != a[MOM_W-1])) begin
      return a[MOM_W-1] ? MOM_MIN : MOM_MAX;
    end
    return s;
  endfunction

  state_e                   state_q, state_d;
  logic                     func_q;
  logic [IN_TDATA_W-1:0]    in_q;
  logic signed [DATA_W-1:0] px, py, pz, tx, ty, fx, fy, fz;
  logic signed [MOM_W-1:0]  tx_s, ty_s;

  logic signed [DATA_W-1:0] mul_a, mul_b;
  logic signed [MOM_W-1:0]  prod_w;
  logic signed [MOM_W-1:0]  prod_q;
  logic signed [MOM_W-1:0]  acc_q, acc_d;
  logic signed [MOM_W-1:0]  mx_q, mx_d, my_q, my_d;
  logic signed [MOM_W-1:0]  numx_q, numx_d, numy_q, numy_d;
  logic signed [DEN_W-1:0]  total_q, total_d;

  logic signed [MOM_W-1:0]  lmx_q, lmx_d, lmy_q, lmy_d;
  logic signed [DATA_W-1:0] lfz_q, lfz_d;

  logic signed [DATA_W-1:0] rawx_q, rawx_d, rawy_q, rawy_d;
  logic signed [DATA_W-1:0] avgx_q, avgx_d, avgy_q, avgy_d;
  logic                     nc_q, nc_d;

  logic signed [SUM_W-1:0]  sumx_q, sumx_d, sumy_q, sumy_d;
  logic [CNT_W-1:0]         fill_q, fill_d;
  logic [PTR_W-1:0]         wp_q, wp_d;
  logic [CNT_W-1:0]         wl_q, wl_d;
  logic [CNT_W-1:0]         wp_next;
  logic                     ring_full;

  logic                     ram_we;
  logic [ENTRY_W-1:0]       ram_rdata;
  logic signed [DATA_W-1:0] old_x, old_y;

  div_req_t                 div_req;
  div_rsp_t                 div_rsp;

  logic                     out_valid_q, out_valid_d;
  logic [OUT_TDATA_W-1:0]   out_data_q, out_data_d;
  logic                     out_user_q, out_user_d;
  logic                     out_load;

  // Unpack the held input transaction
  assign px = in_q[0*DATA_W +: DATA_W];
  assign py = in_q[1*DATA_W +: DATA_W];
  assign pz = in_q[2*DATA_W +: DATA_W];
  assign tx = in_q[3*DATA_W +: DATA_W];
  assign ty = in_q[4*DATA_W +: DATA_W];
  assign fx = in_q[5*DATA_W +: DATA_W];
  assign fy = in_q[6*DATA_W +: DATA_W];
  assign fz = in_q[7*DATA_W +: DATA_W];

  // Torques scaled into the Q32 moment format
  assign tx_s = {{(MOM_W-DATA_W-FRAC_W){tx[DATA_W-1]}}, tx, {FRAC_W{1'b0}}};
  assign ty_s = {{(MOM_W-DATA_W-FRAC_W){ty[DATA_W-1]}}, ty, {FRAC_W{1'b0}}};

  // Shared multiplier operand select
  always_comb begin
    case (state_q)
      ST_M2: begin
        mul_a = pz;
        mul_b = fx;
      end
      ST_M3: begin
        mul_a = fz;
        mul_b = py;
      end
      ST_M4: begin
        mul_a = pz;
        mul_b = fy;
      end
      default: begin
        mul_a = fz;
        mul_b = px;
      end
    endcase
  end

  assign prod_w = mul_a * mul_b;

  // History ring bookkeeping
  assign old_x     = ram_rdata[DATA_W-1:0];
  assign old_y     = ram_rdata[ENTRY_W-1:DATA_W];
  assign ring_full = (fill_q >= wl_q);
  assign wp_next   = CNT_W'(wp_q) + CNT_W'(1);
  assign ram_we    = (state_q == ST_UPD);

  bcop_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (WINDOW_MAX)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_q),
    .wdata_i ({rawy_q, rawx_q}),
    .raddr_i (wp_q),
    .rdata_o (ram_rdata)
  );

  // Divider request: start pulses in the launch states
  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = numx_q;
    div_req.den   = total_q;
    case (state_q)
      ST_DXS: begin
        div_req.start = 1'b1;
      end
      ST_DYS: begin
        div_req.start = 1'b1;
        div_req.num   = numy_q;
      end
      ST_AXS: begin
        div_req.start = (fill_q != '0);
        div_req.num   = MOM_W'(sumx_q);
        div_req.den   = DEN_W'(fill_q);
      end
      ST_AYS: begin
        div_req.start = 1'b1;
        div_req.num   = MOM_W'(sumy_q);
        div_req.den   = DEN_W'(fill_q);
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  bcop_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign out_load      = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready);

  // Sequencer
  always_comb begin
    state_d = state_q;
    acc_d   = acc_q;
    mx_d    = mx_q;
    my_d    = my_q;
    numx_d  = numx_q;
    numy_d  = numy_q;
    total_d = total_q;
    lmx_d   = lmx_q;
    lmy_d   = lmy_q;
    lfz_d   = lfz_q;
    rawx_d  = rawx_q;
    rawy_d  = rawy_q;
    avgx_d  = avgx_q;
    avgy_d  = avgy_q;
    nc_d    = nc_q;
    sumx_d  = sumx_q;
    sumy_d  = sumy_q;
    fill_d  = fill_q;
    wp_d    = wp_q;
    wl_d    = wl_q;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = ST_M1;
        end
      end
      ST_M1: begin
        state_d = ST_M2;
      end
      ST_M2: begin
        acc_d   = sat_sub(prod_q, ty_s);
        state_d = ST_M3;
      end
      ST_M3: begin
        mx_d    = sat_sub(acc_q, prod_q);
        state_d = ST_M4;
      end
      ST_M4: begin
        acc_d   = sat_add(prod_q, tx_s);
        state_d = ST_M5;
      end
      ST_M5: begin
        my_d    = sat_sub(acc_q, prod_q);
        state_d = ST_SUM;
      end
      ST_SUM: begin
        if (!func_q) begin
          // left foot: latch and finish without a result
          lmx_d   = mx_q;
          lmy_d   = my_q;
          lfz_d   = fz;
          state_d = ST_IDLE;
        end else begin
          total_d = DEN_W'(lfz_q) + DEN_W'(fz);
          numx_d  = sat_add(lmx_q, mx_q);
          numy_d  = sat_add(lmy_q, my_q);
          state_d = ST_CHK;
        end
      end
      ST_CHK: begin
        if (total_q == '0) begin
          nc_d    = 1'b1;
          rawx_d  = '0;
          rawy_d  = '0;
          state_d = ST_AXS;
        end else begin
          nc_d    = 1'b0;
          state_d = ST_DXS;
        end
      end
      ST_DXS: begin
        state_d = ST_DXW;
      end
      ST_DXW: begin
        if (div_rsp.done) begin
          rawx_d  = div_rsp.quot;
          state_d = ST_DYS;
        end
      end
      ST_DYS: begin
        state_d = ST_DYW;
      end
      ST_DYW: begin
        if (div_rsp.done) begin
          rawy_d  = div_rsp.quot;
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        // replace the oldest entry once the window is full
        if (ring_full) begin
          sumx_d = sumx_q - SUM_W'(old_x) + SUM_W'(rawx_q);
          sumy_d = sumy_q - SUM_W'(old_y) + SUM_W'(rawy_q);
        end else begin
          sumx_d = sumx_q + SUM_W'(rawx_q);
          sumy_d = sumy_q + SUM_W'(rawy_q);
          fill_d = fill_q + CNT_W'(1);
        end
        wp_d    = (wp_next >= wl_q) ? '0 : wp_next[PTR_W-1:0];
        state_d = ST_AXS;
      end
      ST_AXS: begin
        if (fill_q == '0) begin
          avgx_d  = '0;
          avgy_d  = '0;
          state_d = ST_OUT;
        end else begin
          state_d = ST_AXW;
        end
      end
      ST_AXW: begin
        if (div_rsp.done) begin
          avgx_d  = div_rsp.quot;
          state_d = ST_AYS;
        end
      end
      ST_AYS: begin
        state_d = ST_AYW;
      end
      ST_AYW: begin
        if (div_rsp.done) begin
          avgy_d  = div_rsp.quot;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Window length write: clamp and empty the history
    if (cfg_we_i) begin
      if (cfg_wdata_i == '0) begin
        wl_d = CNT_W'(1);
      end else if (cfg_wdata_i > CNT_W'(WINDOW_MAX)) begin
        wl_d = CNT_W'(WINDOW_MAX);
      end else begin
        wl_d = cfg_wdata_i;
      end
      sumx_d = '0;
      sumy_d = '0;
      fill_d = '0;
      wp_d   = '0;
    end
  end

  // Output register: drop on handshake, load when the result is ready
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_user_d  = out_user_q;
    if (m_axis_tvalid && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
      out_data_d  = {avgy_q, avgx_q, rawy_q, rawx_q};
      out_user_d  = nc_q;
    end
  end

  // Control and model state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      lmx_q       <= '0;
      lmy_q       <= '0;
      lfz_q       <= '0;
      sumx_q      <= '0;
      sumy_q      <= '0;
      fill_q      <= '0;
      wp_q        <= '0;
      wl_q        <= WL_RESET;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      lmx_q       <= lmx_d;
      lmy_q       <= lmy_d;
      lfz_q       <= lfz_d;
      sumx_q      <= sumx_d;
      sumy_q      <= sumy_d;
      fill_q      <= fill_d;
      wp_q        <= wp_d;
      wl_q        <= wl_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_q   <= s_axis_tdata;
      func_q <= s_axis_tuser;
    end
    prod_q     <= prod_w;
    acc_q      <= acc_d;
    mx_q       <= mx_d;
    my_q       <= my_d;
    numx_q     <= numx_d;
    numy_q     <= numy_d;
    total_q    <= total_d;
    rawx_q     <= rawx_d;
    rawy_q     <= rawy_d;
    avgx_q     <= avgx_d;
    avgy_q     <= avgy_d;
    nc_q       <= nc_d;
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // Checks
  `BCOP_ASSERT_SAME(a_ring_in_window, 1'b1,
    (fill_q <= wl_q) && (CNT_W'(wp_q) < wl_q), "history count or pointer beyond window")
  `BCOP_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready,
    !s_axis_tready, "input accepted while an item is in progress")
  `BCOP_ASSERT_SAME(a_div_done_waited, div_rsp.done,
    (state_q == ST_DXW) || (state_q == ST_DYW) || (state_q == ST_AXW) || (state_q == ST_AYW),
    "divider finished outside a wait state")
  `BCOP_ASSERT_SAME(a_no_contact_raw_zero, m_axis_tvalid && m_axis_tuser,
    m_axis_tdata[2*DATA_W-1:0] == '0, "no-contact result with nonzero raw value")

endmodule
